>>> rtl/frustum_culling_test_defines.svh
// assertion macros for the frustum culling block
`ifndef FRUSTUM_CULLING_TEST_DEFINES_SVH
`define FRUSTUM_CULLING_TEST_DEFINES_SVH

// same-cycle implication
`define FCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frustum culling assertion failed");

// next-cycle implication
`define FCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frustum culling assertion failed");

`endif

>>> rtl/fct_pkg.sv
package fct_pkg;

    localparam int NUM_PLANES = 6;
    localparam int PIDX_W     = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int VAL_W      = 32;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int SUM_W      = PROD_W + 3;
    localparam int FRAC_W     = 16;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_POINT  = 2'd1,
        OP_SPHERE = 2'd2,
        OP_BOX    = 2'd3
    } t_op;

    typedef struct packed {
        logic signed [VAL_W-1:0] nx;
        logic signed [VAL_W-1:0] ny;
        logic signed [VAL_W-1:0] nz;
        logic signed [VAL_W-1:0] ofs;
    } t_plane;

    typedef struct packed {
        logic valid;
        logic last;
    } t_issue;

    typedef struct packed {
        logic valid;
        logic last;
        logic fail;
    } t_result;

endpackage

>>> rtl/fct_in_if.sv
interface fct_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [2:0]  plane_index;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scalar_value;

    modport source (
        output valid, op, plane_index, a_x, a_y, a_z, b_x, b_y, b_z, scalar_value,
        input  ready
    );
    modport sink (
        input  valid, op, plane_index, a_x, a_y, a_z, b_x, b_y, b_z, scalar_value,
        output ready
    );
endinterface

>>> rtl/fct_out_if.sv
interface fct_out_if;
    logic valid;
    logic ready;
    logic is_inside;

    modport source (
        output valid, is_inside,
        input  ready
    );
    modport sink (
        input  valid, is_inside,
        output ready
    );
endinterface

>>> rtl/fct_plane_store.sv
module fct_plane_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [fct_pkg::PIDX_W-1:0]  i_widx,
    input  fct_pkg::t_plane             i_wdata,
    input  logic [fct_pkg::PIDX_W-1:0]  i_ridx,
    output fct_pkg::t_plane             o_rdata
);

    fct_pkg::t_plane r_planes [fct_pkg::NUM_PLANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
                r_planes[i] <= '0;
            end
        end else if (i_we) begin
            r_planes[i_widx] <= i_wdata;
        end
    end

    assign o_rdata = r_planes[i_ridx];

endmodule

>>> rtl/fct_dot_unit.sv
module fct_dot_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fct_pkg::t_issue                     i_issue,
    input  fct_pkg::t_plane                     i_plane,
    input  logic signed [fct_pkg::VAL_W-1:0]    i_px,
    input  logic signed [fct_pkg::VAL_W-1:0]    i_py,
    input  logic signed [fct_pkg::VAL_W-1:0]    i_pz,
    input  logic signed [fct_pkg::VAL_W-1:0]    i_bias,
    output fct_pkg::t_result                    o_result
);

    localparam int PW = fct_pkg::PROD_W;
    localparam int SW = fct_pkg::SUM_W;
    localparam int OW = fct_pkg::VAL_W + 1;

    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;
    logic signed [PW-1:0] r_pz;
    logic        [OW-1:0] r_ofs;
    logic [SW-1:0]        r_sum;
    fct_pkg::t_issue      r_st1;
    fct_pkg::t_issue      r_st2;

    // stage 1: three products and offset minus bias
    always_ff @(posedge i_clk) begin
        r_px  <= i_plane.nx * i_px;
        r_py  <= i_plane.ny * i_py;
        r_pz  <= i_plane.nz * i_pz;
        r_ofs <= {i_plane.ofs[fct_pkg::VAL_W-1], i_plane.ofs}
               - {i_bias[fct_pkg::VAL_W-1], i_bias};
    end

    // stage 2: exact sum in q.32 fraction
    always_ff @(posedge i_clk) begin
        r_sum <= {{(SW-PW){r_px[PW-1]}}, r_px}
               + {{(SW-PW){r_py[PW-1]}}, r_py}
               + {{(SW-PW){r_pz[PW-1]}}, r_pz}
               + {{(SW-OW-fct_pkg::FRAC_W){r_ofs[OW-1]}}, r_ofs, {fct_pkg::FRAC_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st1 <= '0;
            r_st2 <= '0;
        end else begin
            r_st1 <= i_issue;
            r_st2 <= r_st1;
        end
    end

    assign o_result.valid = r_st2.valid;
    assign o_result.last  = r_st2.last;
    assign o_result.fail  = !r_sum[SW-1] && (|r_sum);

endmodule

>>> rtl/frustum_culling_test.sv
// channel   dir  transfer when         payload
// i_in      in   valid && ready        op, plane_index, a_*, b_*, scalar_value
// o_res     out  valid && ready        is_inside
//
// a load writes the plane store and gives no result
// a test runs one plane per cycle through the shared dot-product unit;
// the result is registered onto o_res once the last plane leaves the dot unit
// i_in.ready is low from a test transfer until its result is taken
// the result holds on o_res while o_res.ready is low
// synchronous reset clears all planes to zero and idles the sequencer
`include "frustum_culling_test_defines.svh"

module frustum_culling_test (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fct_in_if.sink      i_in,
    fct_out_if.source   o_res
);

    localparam int KW = fct_pkg::PIDX_W;
    localparam int VW = fct_pkg::VAL_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state             r_state, n_state;
    logic [KW-1:0]      r_k, n_k;
    logic               r_inside, n_inside;
    logic               r_out_valid, n_out_valid;
    logic               r_out_inside, n_out_inside;
    logic [1:0]         r_op, n_op;
    logic signed [VW-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_sv;

    fct_pkg::t_plane    w_wplane;
    fct_pkg::t_plane    w_plane;
    fct_pkg::t_issue    w_issue;
    fct_pkg::t_result   w_result;
    logic               w_in_xfer;
    logic               w_load;
    logic               w_test;
    logic               w_out_xfer;
    logic signed [VW-1:0] w_px, w_py, w_pz, w_bias;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = o_res.valid && o_res.ready;
    assign w_load     = w_in_xfer && (i_in.op == fct_pkg::OP_LOAD)
                        && ({1'b0, i_in.plane_index} < 4'(fct_pkg::NUM_PLANES));
    assign w_test     = w_in_xfer && (i_in.op != fct_pkg::OP_LOAD);

    assign w_wplane.nx  = i_in.a_x;
    assign w_wplane.ny  = i_in.a_y;
    assign w_wplane.nz  = i_in.a_z;
    assign w_wplane.ofs = i_in.scalar_value;

    fct_plane_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_load),
        .i_widx  (KW'(i_in.plane_index)),
        .i_wdata (w_wplane),
        .i_ridx  (r_k),
        .o_rdata (w_plane)
    );

    // corner choice for boxes, radius as bias for spheres
    always_comb begin
        w_px   = r_ax;
        w_py   = r_ay;
        w_pz   = r_az;
        w_bias = '0;
        case (r_op)
            fct_pkg::OP_SPHERE: begin
                w_bias = r_sv;
            end
            fct_pkg::OP_BOX: begin
                w_px = w_plane.nx[VW-1] ? r_bx : r_ax;
                w_py = w_plane.ny[VW-1] ? r_by : r_ay;
                w_pz = w_plane.nz[VW-1] ? r_bz : r_az;
            end
            default: begin
            end
        endcase
    end

    assign w_issue.valid = (r_state == S_RUN);
    assign w_issue.last  = (r_state == S_RUN) && (r_k == KW'(fct_pkg::NUM_PLANES - 1));

    fct_dot_unit u_dot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (w_issue),
        .i_plane  (w_plane),
        .i_px     (w_px),
        .i_py     (w_py),
        .i_pz     (w_pz),
        .i_bias   (w_bias),
        .o_result (w_result)
    );

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_inside     = r_inside;
        n_out_valid  = r_out_valid;
        n_out_inside = r_out_inside;
        n_op         = r_op;
        case (r_state)
            S_IDLE: begin
                if (w_test) begin
                    n_state  = S_RUN;
                    n_k      = '0;
                    n_inside = 1'b1;
                    n_op     = i_in.op;
                end
            end
            S_RUN: begin
                if (w_issue.last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_DRAIN: begin
                if (w_result.valid && w_result.last) begin
                    n_state      = S_OUT;
                    n_out_valid  = 1'b1;
                    n_out_inside = r_inside && !w_result.fail;
                end
            end
            S_OUT: begin
                if (w_out_xfer) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_result.valid && w_result.fail) begin
            n_inside = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_inside    <= 1'b1;
            r_out_valid <= 1'b0;
            r_op        <= '0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_inside    <= n_inside;
            r_out_valid <= n_out_valid;
            r_op        <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_inside <= n_out_inside;
        if (w_test) begin
            r_ax <= i_in.a_x;
            r_ay <= i_in.a_y;
            r_az <= i_in.a_z;
            r_bx <= i_in.b_x;
            r_by <= i_in.b_y;
            r_bz <= i_in.b_z;
            r_sv <= i_in.scalar_value;
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_res.valid     = r_out_valid;
    assign o_res.is_inside = r_out_inside;

    `FCT_ASSERT_NOW(a_ready_excl_out, i_clk, i_rst_n, o_res.valid, !i_in.ready)
    `FCT_ASSERT_NOW(a_result_in_flight, i_clk, i_rst_n, w_result.valid,
                    (r_state == S_RUN) || (r_state == S_DRAIN))
    `FCT_ASSERT_NEXT(a_test_starts_run, i_clk, i_rst_n, w_test, (r_state == S_RUN) && (r_k == '0))
    `FCT_ASSERT_NOW(a_index_range, i_clk, i_rst_n, r_state == S_RUN,
                    r_k <= KW'(fct_pkg::NUM_PLANES - 1))

endmodule
